// ===== hw/rtl/subc_pkg.sv =====
// shared types, constants and byte functions for the substring occurrence counter
package subc_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int PAT_W       = 8 * MAX_PATTERN;
    localparam int LEN_W       = 4;
    localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
    localparam int PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 64;
    localparam int OUT_W       = 32;

    // register indexes (byte address / 8)
    localparam logic REG_PATTERN_TEXT   = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // one normalized text beat between the input stage and the match stage
    typedef struct packed {
        logic       valid;
        logic [7:0] norm_byte;
        logic       keep;
        logic       last;
    } subc_beat_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    // line breaks become space, then fold to lower case
    function automatic logic [7:0] normalize(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CHAR_LF || c == CHAR_CR)
        begin
            r = CHAR_SPACE;
        end
        return to_lower(r);
    endfunction

endpackage

// ===== hw/rtl/subc_front.sv =====
// input stage: registers each text beat and normalizes it
module subc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] text_byte
    input  logic                 s_tlast,   // end_of_text
    input  logic                 take,
    output subc_pkg::subc_beat_t beat
);
    import subc_pkg::*;

    subc_beat_t beat_reg;
    subc_beat_t beat_next;
    logic [7:0] norm;

    // stage can load when empty or when its beat moves on this cycle
    assign s_tready = !beat_reg.valid || take;
    assign norm     = normalize(s_tdata);

    always_comb
    begin
        beat_next = beat_reg;
        if (s_tready)
        begin
            beat_next.valid     = s_tvalid;
            beat_next.norm_byte = norm;
            beat_next.keep      = !is_punct(norm);
            beat_next.last      = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat = beat_reg;

endmodule

// ===== hw/rtl/subc_match.sv =====
// match stage: byte history, parallel pattern compare, count and result register
module subc_match (
    input  logic                         clk,
    input  logic                         rst_n,
    input  subc_pkg::subc_beat_t         beat,
    output logic                         take,
    input  logic [subc_pkg::PAT_W-1:0]   pattern_text,
    input  logic [subc_pkg::LEN_W-1:0]   pattern_length,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [subc_pkg::OUT_W-1:0]   m_tdata    // [31:0] match_count
);
    import subc_pkg::*;

    logic [MAX_PATTERN-1:0][7:0] hist_reg;
    logic [MAX_PATTERN-1:0][7:0] hist_next;
    logic [FILL_W-1:0]           filled_reg;
    logic [FILL_W-1:0]           filled_next;
    logic [COUNT_WIDTH-1:0]      total_reg;
    logic [COUNT_WIDTH-1:0]      total_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [OUT_W-1:0]            out_data_reg;
    logic [OUT_W-1:0]            out_data_next;

    logic [MAX_PATTERN-1:0][7:0] hist_shift;
    logic [MAX_PATTERN-1:0][7:0] pat_lc;
    logic [MAX_PATTERN-1:0]      pos_ok;
    logic [FILL_W-1:0]           filled_inc;
    logic [LEN_W-1:0]            len;
    logic                        hit;
    logic [COUNT_WIDTH-1:0]      total_upd;

    // next beat moves in when the result register is free or draining
    assign take = beat.valid && (!out_valid_reg || m_tready);

    // clamp pattern length to the history depth
    assign len = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern_length;

    // history with the incoming byte shifted in at entry 0
    always_comb
    begin
        hist_shift[0] = beat.norm_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            hist_shift[k] = hist_reg[k-1];
        end
    end

    assign filled_inc = (filled_reg == FILL_W'(MAX_PATTERN)) ? filled_reg : filled_reg + 1'b1;

    // lower-cased pattern bytes
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            pat_lc[k] = to_lower(pattern_text[8*k +: 8]);
        end
    end

    // history entry k holds pattern byte len-1-k when the pattern ends here
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            idx       = len - LEN_W'(k) - LEN_W'(1);
            pos_ok[k] = (LEN_W'(k) >= len) || (hist_shift[k] == pat_lc[idx[PTR_W-1:0]]);
        end
    end

    assign hit = (len != '0) && ({1'b0, filled_inc} >= {1'b0, len}) && (&pos_ok);

    // saturating count including this beat
    assign total_upd = (beat.keep && hit && total_reg != '1) ? total_reg + 1'b1 : total_reg;

    always_comb
    begin
        hist_next      = hist_reg;
        filled_next    = filled_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (take)
        begin
            if (beat.keep)
            begin
                hist_next   = hist_shift;
                filled_next = filled_inc;
                total_next  = total_upd;
            end
            if (beat.last)
            begin
                out_valid_next = 1'b1;
                out_data_next  = OUT_W'(total_upd);
                filled_next    = '0;
                total_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            filled_reg    <= filled_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        hist_reg     <= hist_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/substring_occurrence_counter_core.sv =====
// top level: config registers and the two-stage substring counting pipeline
//
// Counts case-insensitive, overlapping occurrences of a 1 to 8 byte pattern
// in a byte stream. One raw text byte arrives per beat on s_tdata, with
// s_tlast marking the final byte of a chunk. CR/LF fold to space, letters
// fold to lower case, and ASCII punctuation is dropped before matching.
// For each beat with s_tlast set, one beat leaves on m_tdata carrying the
// saturating match count of that chunk; the count and history then clear.
// Throughput is one beat per clock unless m_tready holds it: the input
// register and the match stage each hold one beat, and all eight history
// positions are compared in parallel, combinationally. The last beat passes
// the input register, then the match stage sets the m_tvalid register.
// When m_tready is low and a result is waiting, the match stage holds and
// the input register fills, after which s_tready drops.
// Reset clears the pipeline, the count and the history fill, and sets
// pattern_text to zero and pattern_length to one.
// Registers sit on the APB port: pattern_text at 0x0, pattern_length at 0x8.
// Write them only while the pipeline is empty.
module substring_occurrence_counter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // text in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] text_byte
    input  logic                            s_tlast,   // end_of_text
    // count out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [subc_pkg::OUT_W-1:0]      m_tdata,   // [31:0] match_count
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [subc_pkg::ADDR_W-1:0]     paddr,
    input  logic [subc_pkg::DATA_W-1:0]     pwdata,
    output logic [subc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import subc_pkg::*;

    logic [PAT_W-1:0] pattern_text_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic             cfg_write;
    logic             reg_sel;
    subc_beat_t       beat;
    logic             take;

    // register access
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_text_reg   <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_PATTERN_TEXT:   pattern_text_reg   <= pwdata[PAT_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[LEN_W-1:0];
                default:            pattern_text_reg   <= pattern_text_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_PATTERN_TEXT:   prdata = DATA_W'(pattern_text_reg);
            REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length_reg);
            default:            prdata = '0;
        endcase
    end

    subc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take     (take),
        .beat     (beat)
    );

    subc_match u_match (
        .clk            (clk),
        .rst_n          (rst_n),
        .beat           (beat),
        .take           (take),
        .pattern_text   (pattern_text_reg),
        .pattern_length (pattern_length_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

    // a last beat taken by the match stage always produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        take && beat.last |=> m_tvalid)
    else $error("last beat taken without a result");

    // a result only appears after a last beat was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(take && beat.last))
    else $error("result without a last beat");

    // input only stalls when the input register is occupied and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> beat.valid && m_tvalid && !m_tready)
    else $error("input stalled without back-pressure");

    // the match stage never takes a beat while the result register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !m_tvalid || m_tready)
    else $error("beat taken over a waiting result");

endmodule

// ===== tb/substring_count_checker.sv =====
// chunk count predictor and result checker for the substring occurrence counter
module substring_count_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] text_byte
    input  logic                           s_tlast,   // end_of_text
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [subc_pkg::OUT_W-1:0]     m_tdata,   // [31:0] match_count
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [subc_pkg::ADDR_W-1:0]    paddr,
    input  logic [subc_pkg::DATA_W-1:0]    pwdata,
    input  logic                           pready,
    output int                             mismatch_count,
    output int                             awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import subc_pkg::*;

    // register copies as the block should hold them
    logic [63:0]      pattern_bytes = '0;
    logic [3:0]       pattern_len = 4'd1;

    // text history, newest byte in entry 0
    logic [7:0]       history [MAX_PATTERN];
    int unsigned      history_fill = 0;
    logic [31:0]      chunk_total = '0;

    // counts of closed chunks not yet seen on the output
    logic [31:0]      expected_counts [$];
    logic [31:0]      oldest_count;

    initial
    begin
        mismatch_count = 0;
        awaited_count = 0;
        foreach (history[k])
        begin
            history[k] = 8'h00;
        end
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // ascii punctuation never enters the history
    function automatic logic is_dropped(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    task automatic clear_chunk();
        foreach (history[k])
        begin
            history[k] = 8'h00;
        end
        history_fill = 0;
        chunk_total = '0;
    endtask

    // one accepted text beat: shift, compare at the pattern span, close on last
    task automatic track_text_beat(input logic [7:0] raw, input logic last);
        logic [7:0]  c;
        int unsigned span;
        logic        hit;
        c = (raw == CHAR_LF || raw == CHAR_CR) ? CHAR_SPACE : raw;
        c = fold_case(c);
        if (!is_dropped(c))
        begin
            span = (pattern_len > MAX_PATTERN) ? MAX_PATTERN : pattern_len;
            for (int k = MAX_PATTERN - 1; k > 0; k--)
            begin
                history[k] = history[k - 1];
            end
            history[0] = c;
            if (history_fill < MAX_PATTERN)
            begin
                history_fill++;
            end
            if (span > 0 && history_fill >= span)
            begin
                hit = 1'b1;
                for (int k = 0; k < span; k++)
                begin
                    if (history[span - 1 - k] != fold_case(pattern_bytes[8*k +: 8]))
                    begin
                        hit = 1'b0;
                    end
                end
                // saturate rather than wrap
                if (hit && chunk_total != '1)
                begin
                    chunk_total++;
                end
            end
        end
        if (last)
        begin
            expected_counts.push_back(chunk_total);
            clear_chunk();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes = '0;
            pattern_len = 4'd1;
            clear_chunk();
            expected_counts.delete();
        end
        else
        begin
            // count beat against the oldest closed chunk
            if (m_tvalid && m_tready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: match_count expected none, got 0x%08h", $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    oldest_count = expected_counts.pop_front();
                    if (m_tdata !== oldest_count)
                    begin
                        $display("%0t: match_count expected 0x%08h, got 0x%08h",
                                 $time, oldest_count, m_tdata);
                        mismatch_count++;
                    end
                end
            end
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_PATTERN_TEXT, 3'b000})
                begin
                    pattern_bytes = pwdata;
                end
                else if (paddr == {REG_PATTERN_LENGTH, 3'b000})
                begin
                    pattern_len = pwdata[3:0];
                end
            end
            // text beat
            if (s_tvalid && s_tready)
            begin
                track_text_beat(s_tdata, s_tlast);
            end
        end
        awaited_count = expected_counts.size();
    end

endmodule

// ===== tb/substring_occurrence_counter_core_test.sv =====
// stimulus, clock, reset and verdict for the substring occurrence counter core
module substring_occurrence_counter_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import subc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int                   mismatch_count;
    int                   awaited_count;

    // sender state
    bit                   dense_burst = 1'b0;
    int unsigned          beats_sent = 0;
    logic [7:0]           text_beats [$];

    // pattern mirror used to shape the text
    logic [63:0]          cur_pattern = '0;
    logic [3:0]           cur_len = 4'd1;
    int unsigned          cur_span = 1;

    // receiver state
    int                   hold_requests = 0;
    int                   holds_served = 0;
    int                   hold_left = 0;
    int                   ready_left = 0;
    int                   stall_left = 0;

    substring_occurrence_counter_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    substring_count_checker count_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // gap lengths: mostly none or short, a few long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] punct_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h21 + 8'($urandom_range(0, 14));
            1:       return 8'h3A + 8'($urandom_range(0, 6));
            2:       return 8'h5B + 8'($urandom_range(0, 5));
            default: return 8'h7B + 8'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [7:0] letter_byte();
        logic [7:0] v;
        v = 8'h61 + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1)
        begin
            v = v - 8'h20;
        end
        return v;
    endfunction

    // pattern bytes from a small alphabet so that matches and overlaps are common
    function automatic logic [7:0] pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return letter_byte();
        end
        else if (r < 65)
        begin
            return CHAR_SPACE;
        end
        else if (r < 75)
        begin
            return 8'h30 + 8'($urandom_range(0, 1));
        end
        else if (r < 85)
        begin
            return 8'h80 | 8'($urandom_range(0, 127));
        end
        else if (r < 90)
        begin
            return 8'h00;
        end
        else if (r < 95)
        begin
            return punct_byte();
        end
        return ($urandom_range(0, 1) == 1) ? CHAR_LF : CHAR_CR;
    endfunction

    // a text byte that folds to byte c unless c is CR or LF, in a random spelling
    function automatic logic [7:0] text_variant(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (v >= 8'h41 && v <= 8'h5A)
        begin
            v = v + 8'h20;
        end
        if (v >= 8'h61 && v <= 8'h7A && $urandom_range(0, 1) == 1)
        begin
            v = v - 8'h20;
        end
        else if (v == CHAR_SPACE)
        begin
            case ($urandom_range(0, 2))
                0:       v = CHAR_LF;
                1:       v = CHAR_CR;
                default: v = CHAR_SPACE;
            endcase
        end
        return v;
    endfunction

    function automatic logic [7:0] random_text_byte();
        int r;
        int unsigned idx;
        r = $urandom_range(0, 99);
        idx = $urandom_range(0, cur_span - 1);
        if (r < 35)
        begin
            return 8'($urandom_range(0, 255));
        end
        else if (r < 65)
        begin
            return text_variant(cur_pattern[8*idx +: 8]);
        end
        else if (r < 80)
        begin
            return punct_byte();
        end
        else if (r < 90)
        begin
            return text_variant(CHAR_SPACE);
        end
        return letter_byte();
    endfunction

    // mostly embedded pattern copies, some with punctuation inside, plus noise
    task automatic build_chunk(input int unsigned n);
        text_beats.delete();
        while (text_beats.size() < n)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                for (int k = 0; k < cur_span; k++)
                begin
                    text_beats.push_back(text_variant(cur_pattern[8*k +: 8]));
                    if (k + 1 < cur_span && $urandom_range(0, 9) == 0)
                    begin
                        text_beats.push_back(punct_byte());
                    end
                end
            end
            else
            begin
                text_beats.push_back(random_text_byte());
            end
        end
    endtask

    // offer one text beat, wait for the handshake, then maybe idle
    task automatic send_text_beat(input logic [7:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        beats_sent++;
        gap = dense_burst ? 0 : idle_span();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_chunk();
        for (int k = 0; k < text_beats.size(); k++)
        begin
            send_text_beat(text_beats[k], k == text_beats.size() - 1);
        end
    endtask

    // stop sending until every closed chunk has been counted out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // apb write: setup phase, then access phase, then idle
    task automatic write_reg(input logic idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (idx == REG_PATTERN_TEXT)
        begin
            cur_pattern = value;
        end
        else
        begin
            cur_len = value[3:0];
        end
        cur_span = (cur_len == 0) ? 1 : ((cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len);
    endtask

    task automatic set_random_pattern(input bit both);
        logic [63:0] pattern_word;
        logic [3:0]  len;
        int          r;
        int unsigned which;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            pattern_word = '0;
        end
        else if (r < 10)
        begin
            pattern_word = '1;
        end
        else if (r < 20)
        begin
            pattern_word = {$urandom, $urandom};
        end
        else
        begin
            for (int k = 0; k < 8; k++)
            begin
                pattern_word[8*k +: 8] = pattern_char();
            end
        end
        r = $urandom_range(0, 99);
        if (r < 7)
        begin
            len = 4'd0;
        end
        else if (r < 15)
        begin
            len = 4'($urandom_range(9, 15));
        end
        else if (r < 25)
        begin
            len = 4'd8;
        end
        else
        begin
            len = 4'($urandom_range(1, 7));
        end
        which = both ? 3 : $urandom_range(1, 3);
        if (which[0])
        begin
            write_reg(REG_PATTERN_TEXT, pattern_word);
        end
        if (which[1])
        begin
            write_reg(REG_PATTERN_LENGTH, {60'd0, len});
        end
    endtask

    // receiver: random ready runs and stalls, plus requested long hold-offs
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (ready_left > 0)
        begin
            m_tready <= 1'b1;
            ready_left--;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            ready_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 3);
            stall_left = idle_span();
        end
    end

    initial
    begin
        int unsigned random_start;
        int          chunks;
        int          chunk_len;
        int          r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset pattern is a single zero byte
        send_text_beat(8'h00, 1'b0);
        send_text_beat(8'hFF, 1'b0);
        send_text_beat(8'h00, 1'b1);
        drain_results();

        // mixed case pattern, punctuation inside a match, lone dropped last byte
        write_reg(REG_PATTERN_TEXT, 64'h4261);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        send_text_beat(8'h41, 1'b0);
        send_text_beat(8'h21, 1'b0);
        send_text_beat(8'h42, 1'b0);
        send_text_beat(8'h61, 1'b0);
        send_text_beat(8'h62, 1'b1);
        send_text_beat(8'h2E, 1'b1);
        drain_results();

        // line breaks fold to space
        write_reg(REG_PATTERN_TEXT, 64'h5820);
        send_text_beat(CHAR_CR, 1'b0);
        send_text_beat(8'h58, 1'b0);
        send_text_beat(CHAR_LF, 1'b0);
        send_text_beat(8'h78, 1'b1);
        drain_results();

        // empty pattern never matches
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        send_text_beat(8'h61, 1'b0);
        send_text_beat(8'h00, 1'b1);
        drain_results();

        // oversized length clamps to eight, overlapping all-ones matches
        write_reg(REG_PATTERN_TEXT, '1);
        write_reg(REG_PATTERN_LENGTH, 64'd15);
        for (int k = 0; k < 9; k++)
        begin
            send_text_beat(8'hFF, k == 8);
        end
        drain_results();

        // random phases, each with its own pattern setting
        random_start = beats_sent;
        for (int phase = 0; beats_sent - random_start < 1750; phase++)
        begin
            set_random_pattern(phase == 0);
            dense_burst = ($urandom_range(0, 3) == 0);
            chunks = $urandom_range(2, 8);
            if (phase == 2)
            begin
                // receiver holds off while short chunks keep coming
                dense_burst = 1'b1;
                hold_requests++;
                chunks = 40;
            end
            repeat (chunks)
            begin
                r = $urandom_range(0, 99);
                if (phase == 2)
                begin
                    chunk_len = $urandom_range(1, 3);
                end
                else if (r < 70)
                begin
                    chunk_len = $urandom_range(1, 12);
                end
                else if (r < 95)
                begin
                    chunk_len = $urandom_range(13, 40);
                end
                else
                begin
                    chunk_len = $urandom_range(60, 150);
                end
                build_chunk(chunk_len);
                send_chunk();
                if ($urandom_range(0, 19) == 0)
                begin
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/subc_pkg.sv
hw/rtl/subc_front.sv
hw/rtl/subc_match.sv
hw/rtl/substring_occurrence_counter_core.sv
tb/substring_count_checker.sv
tb/substring_occurrence_counter_core_test.sv
